[rtl/mrw_pkg.sv]
// Shared types and constants for the message ring writer.
// No dependencies; compiled first.
`default_nettype none

package mrw_pkg;

	// Fixed field widths of the item channels and the config register
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 12;
	localparam int OFS_W       = 12;
	localparam int RING_SIZE_W = 13;
	localparam int STATUS_W    = 2;

	// Compare width: covers a 16-bit header word plus a header and a length
	localparam int CMP_W = 17;

	localparam logic [RING_SIZE_W-1:0] RING_SIZE_RESET = 13'd4096;

	typedef enum logic [STATUS_W-1:0] {
		ST_WRITTEN  = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_ZERO_LEN = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_STREAM = 4'b0001,
		S_DECIDE = 4'b0010,
		S_HDR    = 4'b0100,
		S_FINISH = 4'b1000
	} mrw_state_t;

endpackage

`default_nettype wire

[rtl/mrw_ifs.sv]
// Valid/ready channel interfaces for message bytes in and status items out.
// Depends on mrw_pkg.
`default_nettype none

interface mrw_in_if
	import mrw_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   payload_byte;
	logic                first_byte;
	logic                last_byte;
	logic [LEN_W-1:0]    message_length;
	logic [OFS_W-1:0]    reader_offset;

	modport source (
		output valid, payload_byte, first_byte, last_byte, message_length, reader_offset,
		input  ready
	);
	modport sink (
		input  valid, payload_byte, first_byte, last_byte, message_length, reader_offset,
		output ready
	);
endinterface

interface mrw_out_if
	import mrw_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [OFS_W-1:0]    item_offset;
	logic [OFS_W-1:0]    next_offset;
	logic                wrapped;

	modport source (
		output valid, status, item_offset, next_offset, wrapped,
		input  ready
	);
	modport sink (
		input  valid, status, item_offset, next_offset, wrapped,
		output ready
	);
endinterface

`default_nettype wire

[rtl/message_ring_writer_unit.sv]
// Message ring writer: places headers and payload bytes in a byte ring memory.
// Depends on mrw_pkg and the channel interfaces in mrw_ifs.sv.
//
// Usage: payload bytes after the first item of a message are taken one per
// cycle, but for the closing stall below, and written straight into the ring
// memory. A first item that gets placed holds the input while it is taken,
// while the tail header read from the memory is decided on, while each header
// byte goes through the memory's single write port (when the message wraps to
// offset 0, the old tail's next word is first cleared that way), and while
// the first payload byte is stored. A rejected or zero-length first item
// holds the input while it is taken, decided on and finished. The status item
// sits in an output register, so bytes keep flowing while it waits. Only a
// closing item, or a first item that also closes its message, stalls while
// an earlier status item is still untaken. No clearing pass is needed after
// reset: the header at offset 0 reads as cleared until the first header is written.
`default_nettype none

module message_ring_writer_unit
	import mrw_pkg::*;
#(
	parameter int RING_BYTES        = 4096,
	parameter int HEADER_WORD_BYTES = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [RING_SIZE_W-1:0] cfg_wdata,
	mrw_in_if.sink                 msg_in,
	mrw_out_if.source              res_out
);

	localparam int AW        = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
	localparam int WB        = 8 * HEADER_WORD_BYTES;
	localparam int HDR_BYTES = 2 * HEADER_WORD_BYTES;
	localparam int HJ_W      = $clog2(HDR_BYTES);

	localparam logic [AW-1:0]    LAST_ADDR  = AW'(RING_BYTES - 1);
	localparam logic [CMP_W-1:0] RING_CMP   = CMP_W'(RING_BYTES);
	localparam logic [CMP_W-1:0] HDR_CMP    = CMP_W'(HDR_BYTES);
	localparam logic [HJ_W-1:0]  HJ_LAST    = HJ_W'(HDR_BYTES - 1);
	localparam logic [HJ_W-1:0]  PATCH_LAST = HJ_W'(HEADER_WORD_BYTES - 1);

	// Control state
	mrw_state_t             state_q;
	logic [RING_SIZE_W-1:0] ring_size_q;
	logic [AW-1:0]          tail_q;
	logic [AW-1:0]          ptr_q;
	logic [LEN_W-1:0]       left_q;
	logic                   accepting_q;
	logic                   open_q;
	status_t                pend_q;
	logic [OFS_W-1:0]       placed_off_q;
	logic [OFS_W-1:0]       placed_next_q;
	logic                   placed_wrap_q;
	logic                   hdr_valid_q;
	logic                   patch_q;
	logic [HJ_W-1:0]        hj_q;
	logic                   ovld_q;

	// Held first item and header payload
	logic [BYTE_W-1:0]      byte_s1;
	logic                   last_s1;
	logic [LEN_W-1:0]       len_s1;
	logic [OFS_W-1:0]       reader_s1;
	logic [AW-1:0]          pbase_q;
	logic [CMP_W-1:0]       nxt_q;

	// Output register payload
	status_t                ost_q;
	logic [OFS_W-1:0]       ooff_q;
	logic [OFS_W-1:0]       onxt_q;
	logic                   owrap_q;

	// Ring memory and its registered read of the tail's next word
	logic [BYTE_W-1:0]      ring_mem [RING_BYTES];
	logic [BYTE_W-1:0]      rd0_q;
	logic [BYTE_W-1:0]      rd1_q;
	logic [AW-1:0]          tail_p1;

	logic                   in_acc;
	logic                   out_free;
	logic                   fin_go;
	logic                   stream_wr;
	logic                   fin_wr;
	logic                   load_stream;
	logic                   load_fin;
	logic                   hdr_done;
	logic [AW-1:0]          ptr_inc;

	logic                   mem_we;
	logic [AW-1:0]          mem_wa;
	logic [BYTE_W-1:0]      mem_wd;
	logic [2*WB-1:0]        hdr_vec;

	logic [CMP_W-1:0]       cand;
	logic [CMP_W-1:0]       eff;
	logic [CMP_W-1:0]       need;
	logic [CMP_W-1:0]       sum;
	logic [CMP_W-1:0]       rdr;
	logic                   fit_fail;
	logic                   room_at_zero;
	logic                   dec_zero;
	logic                   dec_wrap;
	logic                   dec_rej;
	logic                   dec_place;
	logic [CMP_W-1:0]       place_c;
	logic [CMP_W-1:0]       place_n;

	// Handshakes
	assign in_acc   = msg_in.valid && msg_in.ready;
	assign out_free = !ovld_q || res_out.ready;
	assign msg_in.ready = (state_q == S_STREAM) &&
		(!msg_in.last_byte || msg_in.first_byte || !open_q || out_free);

	assign fin_go      = (state_q == S_FINISH) && (!last_s1 || out_free);
	assign stream_wr   = in_acc && !msg_in.first_byte && open_q && accepting_q &&
		(left_q != '0);
	assign fin_wr      = fin_go && accepting_q && (left_q != '0);
	assign load_stream = in_acc && !msg_in.first_byte && open_q && msg_in.last_byte;
	assign load_fin    = fin_go && last_s1;
	assign hdr_done    = !patch_q && (hj_q == HJ_LAST);
	assign ptr_inc     = (ptr_q == LAST_ADDR) ? '0 : ptr_q + 1'b1;
	assign tail_p1     = tail_q + 1'b1;

	// Placement decision on the held first item and the tail's next word
	assign cand = hdr_valid_q ? CMP_W'({rd1_q, rd0_q}) : '0;
	assign eff  = (CMP_W'(ring_size_q) > RING_CMP) ? RING_CMP : CMP_W'(ring_size_q);
	assign need = CMP_W'(len_s1) + HDR_CMP;
	assign sum  = cand + need;
	assign rdr  = CMP_W'(reader_s1);

	assign fit_fail     = (cand >= eff) || (sum >= eff);
	assign room_at_zero = rdr >= need;
	assign dec_zero     = (len_s1 == '0);
	assign dec_wrap     = !dec_zero && fit_fail && room_at_zero;
	assign dec_rej      = !dec_zero && ((fit_fail && !room_at_zero) ||
		(!fit_fail && (cand < rdr) && (sum >= rdr)));
	assign dec_place    = !dec_zero && !dec_rej;
	assign place_c      = dec_wrap ? '0 : cand;
	assign place_n      = dec_wrap ? need : sum;

	// Header bytes: next word then length word, little endian
	assign hdr_vec = {WB'(len_s1), WB'(nxt_q)};

	// Memory write port select
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q;
		mem_wd = msg_in.payload_byte;
		if (state_q == S_HDR) begin
			mem_we = 1'b1;
			if (patch_q) begin
				mem_wa = pbase_q + AW'(hj_q);
				mem_wd = '0;
			end else begin
				mem_wa = tail_q + AW'(hj_q);
				mem_wd = hdr_vec[{hj_q, 3'b000} +: BYTE_W];
			end
		end else if (fin_wr) begin
			mem_we = 1'b1;
			mem_wd = byte_s1;
		end else if (stream_wr) begin
			mem_we = 1'b1;
		end
	end

	// Ring memory: one write port, two registered reads at the tail
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_wa] <= mem_wd;
		end
		rd0_q <= ring_mem[tail_q];
		rd1_q <= ring_mem[tail_p1];
	end

	// Sequencer and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_STREAM;
			ring_size_q   <= RING_SIZE_RESET;
			tail_q        <= '0;
			ptr_q         <= '0;
			left_q        <= '0;
			accepting_q   <= 1'b0;
			open_q        <= 1'b0;
			pend_q        <= ST_WRITTEN;
			placed_off_q  <= '0;
			placed_next_q <= '0;
			placed_wrap_q <= 1'b0;
			hdr_valid_q   <= 1'b0;
			patch_q       <= 1'b0;
			hj_q          <= '0;
		end else begin
			if (cfg_we) begin
				ring_size_q <= cfg_wdata;
			end
			unique case (state_q)
				S_STREAM: begin
					if (in_acc && msg_in.first_byte) begin
						state_q <= S_DECIDE;
					end else if (in_acc && open_q) begin
						if (stream_wr) begin
							ptr_q <= ptr_inc;
						end
						if (msg_in.last_byte) begin
							open_q      <= 1'b0;
							accepting_q <= 1'b0;
							left_q      <= '0;
						end else if (stream_wr) begin
							left_q <= left_q - 1'b1;
						end
					end
				end
				S_DECIDE: begin
					open_q        <= 1'b1;
					accepting_q   <= dec_place;
					left_q        <= dec_place ? len_s1 : '0;
					placed_off_q  <= dec_place ? OFS_W'(place_c) : '0;
					placed_next_q <= dec_place ? OFS_W'(place_n) : '0;
					placed_wrap_q <= dec_wrap;
					if (dec_zero) begin
						pend_q <= ST_ZERO_LEN;
					end else if (dec_rej) begin
						pend_q <= ST_TOO_LONG;
					end else begin
						pend_q <= ST_WRITTEN;
					end
					if (dec_place) begin
						tail_q  <= AW'(place_c);
						ptr_q   <= AW'(place_c + HDR_CMP);
						patch_q <= dec_wrap;
						hj_q    <= '0;
						state_q <= S_HDR;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_HDR: begin
					if (patch_q && (hj_q == PATCH_LAST)) begin
						patch_q <= 1'b0;
						hj_q    <= '0;
					end else if (hdr_done) begin
						hdr_valid_q <= 1'b1;
						state_q     <= S_FINISH;
					end else begin
						hj_q <= hj_q + 1'b1;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						if (fin_wr) begin
							ptr_q <= ptr_inc;
						end
						if (last_s1) begin
							open_q      <= 1'b0;
							accepting_q <= 1'b0;
							left_q      <= '0;
						end else if (fin_wr) begin
							left_q <= left_q - 1'b1;
						end
						state_q <= S_STREAM;
					end
				end
				default: begin
					state_q <= S_STREAM;
				end
			endcase
		end
	end

	// Held first item, wrap patch base and header next value
	always_ff @(posedge clk) begin
		if (in_acc && msg_in.first_byte) begin
			byte_s1   <= msg_in.payload_byte;
			last_s1   <= msg_in.last_byte;
			len_s1    <= msg_in.message_length;
			reader_s1 <= msg_in.reader_offset;
		end
		if (state_q == S_DECIDE) begin
			pbase_q <= tail_q;
			nxt_q   <= place_n;
		end
	end

	// Status item output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (load_stream || load_fin) begin
			ovld_q <= 1'b1;
		end else if (res_out.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_stream || load_fin) begin
			ost_q   <= pend_q;
			ooff_q  <= placed_off_q;
			onxt_q  <= placed_next_q;
			owrap_q <= placed_wrap_q;
		end
	end

	assign res_out.valid       = ovld_q;
	assign res_out.status      = ost_q;
	assign res_out.item_offset = ooff_q;
	assign res_out.next_offset = onxt_q;
	assign res_out.wrapped     = owrap_q;

endmodule

`default_nettype wire

[rtl/mrw_checker.sv]
// Port-level checks for the message ring writer, bound to its top level.
// Depends on mrw_pkg and message_ring_writer_unit.
`default_nettype none

module mrw_checker
	import mrw_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                in_first,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [OFS_W-1:0]    item_offset,
	input wire logic [OFS_W-1:0]    next_offset,
	input wire logic                wrapped
);

	// A stalled status item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(item_offset) && $stable(next_offset) && $stable(wrapped))
		else $error("status item changed while stalled");

	// Rejected messages report no placement
	a_reject_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_WRITTEN) |->
		(item_offset == '0) && (next_offset == '0) && !wrapped)
		else $error("rejected message reports a placement");

	// A wrapped message sits at offset zero and was written
	a_wrap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wrapped |-> (item_offset == '0) && (status == ST_WRITTEN))
		else $error("wrapped message not at offset zero");

	// The placement decision takes the cycle after a first item
	a_first_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_first |=> !in_ready)
		else $error("item taken during placement decision");

endmodule

bind message_ring_writer_unit mrw_checker u_mrw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (msg_in.valid),
	.in_ready    (msg_in.ready),
	.in_first    (msg_in.first_byte),
	.out_valid   (res_out.valid),
	.out_ready   (res_out.ready),
	.status      (res_out.status),
	.item_offset (res_out.item_offset),
	.next_offset (res_out.next_offset),
	.wrapped     (res_out.wrapped)
);

`default_nettype wire

[sim/tb_message_ring_writer_unit.sv]
`timescale 1ns / 100ps
// Testbench for message_ring_writer_unit: streams messages into the ring and checks statuses.
// Depends on mrw_pkg, mrw_ifs.sv and the unit itself; holds its own placement predictor.

// Placement predictor: mirrors the byte ring and keeps the statuses still owed by the block
class placement_scoreboard #(int RING_BYTES = 4096, int WORD_BYTES = 8);
	localparam int HDR_BYTES = 2 * WORD_BYTES;

	typedef struct packed {
		mrw_pkg::status_t status;
		logic [11:0]      item_offset;
		logic [11:0]      next_offset;
		logic             wrapped;
	} placement_t;

	logic [7:0]      ring_mem [RING_BYTES];
	int unsigned     tail_ofs;
	int unsigned     write_ptr;
	int unsigned     bytes_left;
	bit              accepting;
	bit              msg_open;
	mrw_pkg::status_t pend_status;
	int unsigned     placed_ofs;
	int unsigned     placed_next;
	bit              placed_wrap;
	int unsigned     ring_size;
	placement_t      owed_q[$];

	int unsigned mismatches;
	int unsigned checked;
	int unsigned n_written;
	int unsigned n_wrapped;
	int unsigned n_too_long;
	int unsigned n_zero_len;

	function new();
		foreach (ring_mem[i]) ring_mem[i] = 8'h00;
		tail_ofs    = 0;
		write_ptr   = 0;
		bytes_left  = 0;
		accepting   = 0;
		msg_open    = 0;
		pend_status = mrw_pkg::ST_WRITTEN;
		placed_ofs  = 0;
		placed_next = 0;
		placed_wrap = 0;
		ring_size   = 4096;
	endfunction

	function void set_ring_size(logic [12:0] v);
		ring_size = v;
	endfunction

	// Little-endian header word
	function longint unsigned read_word(int unsigned at);
		longint unsigned v;
		v = 0;
		for (int k = 0; k < WORD_BYTES; k++)
			v |= longint'(ring_mem[(at + k) % RING_BYTES]) << (8 * k);
		return v;
	endfunction

	function void write_word(int unsigned at, longint unsigned v);
		for (int k = 0; k < WORD_BYTES; k++)
			ring_mem[(at + k) % RING_BYTES] = v[8*k +: 8];
	endfunction

	function int unsigned next_candidate();
		return int'(read_word(tail_ofs));
	endfunction

	// Decide placement of a new message from the tail header
	function void open_message(int unsigned len, int unsigned rdr);
		int unsigned     eff;
		longint unsigned cand;
		longint unsigned need;
		bit              wrap;
		eff  = (ring_size < RING_BYTES) ? ring_size : RING_BYTES;
		cand = read_word(tail_ofs);
		need = longint'(len) + HDR_BYTES;
		wrap = 0;
		msg_open    = 1;
		accepting   = 0;
		bytes_left  = 0;
		pend_status = mrw_pkg::ST_WRITTEN;
		placed_ofs  = 0;
		placed_next = 0;
		placed_wrap = 0;
		if (len == 0) begin
			pend_status = mrw_pkg::ST_ZERO_LEN;
			return;
		end
		if (cand >= eff || cand + need >= eff) begin
			// no room before ring end: wrap only if the reader is far enough in
			if (longint'(rdr) >= need) begin
				write_word(tail_ofs, 0);
				cand = 0;
				wrap = 1;
			end else begin
				pend_status = mrw_pkg::ST_TOO_LONG;
				return;
			end
		end else if (cand < rdr && cand + need >= rdr) begin
			// would run into the reader ahead
			pend_status = mrw_pkg::ST_TOO_LONG;
			return;
		end
		write_word(int'(cand), cand + need);
		write_word(int'(cand) + WORD_BYTES, len);
		tail_ofs    = int'(cand) % RING_BYTES;
		write_ptr   = (int'(cand) + HDR_BYTES) % RING_BYTES;
		bytes_left  = len;
		accepting   = 1;
		placed_ofs  = int'(cand);
		placed_next = int'(cand + need);
		placed_wrap = wrap;
	endfunction

	// Accepted input item; returns 1 when the block makes use of it
	function bit note_byte(logic [7:0] b, logic f, logic l, logic [11:0] len,
			logic [11:0] rdr);
		placement_t p;
		if (f)
			open_message(len, rdr);
		if (!msg_open)
			return 0;
		if (accepting && bytes_left > 0) begin
			ring_mem[write_ptr % RING_BYTES] = b;
			write_ptr  = (write_ptr + 1) % RING_BYTES;
			bytes_left = bytes_left - 1;
		end
		if (l) begin
			p.status      = pend_status;
			p.item_offset = (pend_status == mrw_pkg::ST_WRITTEN) ? placed_ofs[11:0] : 12'd0;
			p.next_offset = (pend_status == mrw_pkg::ST_WRITTEN) ? placed_next[11:0] : 12'd0;
			p.wrapped     = (pend_status == mrw_pkg::ST_WRITTEN) ? placed_wrap : 1'b0;
			owed_q.push_back(p);
			case (pend_status)
				mrw_pkg::ST_WRITTEN: begin
					n_written++;
					if (placed_wrap) n_wrapped++;
				end
				mrw_pkg::ST_TOO_LONG: n_too_long++;
				default: n_zero_len++;
			endcase
			msg_open   = 0;
			accepting  = 0;
			bytes_left = 0;
		end
		return 1;
	endfunction

	function void flag(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR: %s", msg);
	endfunction

	function void check_status(logic [1:0] st, logic [11:0] io, logic [11:0] no, logic w);
		placement_t want;
		checked++;
		if (owed_q.size() == 0) begin
			flag($sformatf("status item (st %0d ofs %0d next %0d wrap %0d) with none owed",
				st, io, no, w));
			return;
		end
		want = owed_q.pop_front();
		if (st !== want.status || io !== want.item_offset || no !== want.next_offset ||
				w !== want.wrapped)
			flag($sformatf("status #%0d: got st %0d ofs %0d next %0d wrap %0d, want %0d %0d %0d %0d",
				checked, st, io, no, w, want.status, want.item_offset, want.next_offset,
				want.wrapped));
	endfunction

	function int unsigned outstanding();
		return owed_q.size();
	endfunction

	function int unsigned failures();
		return mismatches + owed_q.size();
	endfunction
endclass

module tb_message_ring_writer_unit;
	import mrw_pkg::*;

	localparam int RING_BYTES   = 4096;
	localparam int WORD_BYTES   = 8;
	localparam int CLK_PERIOD   = 12;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASE_ITEMS  = 250;
	localparam int N_PHASES     = 7;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [RING_SIZE_W-1:0] cfg_wdata;

	mrw_in_if  msg_ch ();
	mrw_out_if res_ch ();

	placement_scoreboard #(RING_BYTES, WORD_BYTES) sb;

	int unsigned cycle_count;
	int unsigned items_used;
	int unsigned messages_sent;
	int          send_mode;
	int          sink_mode;

	message_ring_writer_unit #(
		.RING_BYTES        (RING_BYTES),
		.HEADER_WORD_BYTES (WORD_BYTES)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.msg_in    (msg_ch),
		.res_out   (res_ch)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL message_ring_writer_unit");
		$finish;
	end

	// Gap before an item: mode 0 never idles, mode 1 rarely, mode 2 often
	function automatic int unsigned pick_gap(int mode);
		int unsigned r;
		if (mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < ((mode == 1) ? 75 : 45))
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: random stalls plus one long hold-off to back up the input
	initial begin
		int unsigned hold_left;
		bit          long_done;
		hold_left = 0;
		long_done = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else if (!long_done && sb.checked >= 40) begin
				long_done = 1;
				hold_left = 600;
				res_ch.ready <= 1'b0;
			end else begin
				hold_left = pick_gap(sink_mode);
				res_ch.ready <= (hold_left == 0);
			end
		end
	end

	// Status items taken by the testbench
	always @(posedge clk) begin
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			sb.check_status(res_ch.status, res_ch.item_offset, res_ch.next_offset,
				res_ch.wrapped);
	end

	// One input item, held until taken
	task automatic push_byte(input logic [7:0] b, input logic f, input logic l,
			input logic [11:0] len, input logic [11:0] rdr);
		int unsigned gap;
		gap = pick_gap(send_mode);
		@(negedge clk);
		if (gap > 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_ch.valid          <= 1'b1;
		msg_ch.payload_byte   <= b;
		msg_ch.first_byte     <= f;
		msg_ch.last_byte      <= l;
		msg_ch.message_length <= len;
		msg_ch.reader_offset  <= rdr;
		do
			@(posedge clk);
		while (msg_ch.ready !== 1'b1);
		if (sb.note_byte(b, f, l, len, rdr))
			items_used++;
	endtask

	// A message of nbytes items; length and reader only matter on the first
	task automatic send_message(input int unsigned len, input int unsigned rdr,
			input int unsigned nbytes, input bit closes);
		messages_sent++;
		for (int unsigned i = 0; i < nbytes; i++)
			push_byte(8'($urandom_range(0, 255)), i == 0, closes && (i == nbytes - 1),
				(i == 0) ? len[11:0] : 12'($urandom_range(0, 4095)),
				(i == 0) ? rdr[11:0] : 12'($urandom_range(0, 4095)));
	endtask

	// Reader offset that mostly lets the message in, sometimes blocks it
	function automatic int unsigned pick_reader(int unsigned len);
		int unsigned need;
		int unsigned r;
		need = len + 2 * WORD_BYTES;
		r = $urandom_range(0, 99);
		if (r < 45)
			return sb.next_candidate() % RING_BYTES;
		if (r < 70 && need <= 4095)
			return $urandom_range(4095, need);
		if (r < 85)
			return $urandom_range(0, 4095);
		return 0;
	endfunction

	task automatic random_message();
		int unsigned r;
		int unsigned len;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			// well-formed message
			r = $urandom_range(0, 99);
			len = (r < 70) ? $urandom_range(1, 24) :
				(r < 95) ? $urandom_range(25, 120) : $urandom_range(121, 400);
			send_message(len, pick_reader(len), len, 1'b1);
		end else if (r < 78) begin
			// closed early, any length
			len = $urandom_range(0, 4095);
			send_message(len, pick_reader(len), $urandom_range(1, 4), 1'b1);
		end else if (r < 84) begin
			// trailing bytes past the length
			len = $urandom_range(1, 6);
			send_message(len, pick_reader(len), len + $urandom_range(1, 4), 1'b1);
		end else if (r < 88) begin
			// left open, the next first item abandons it
			len = $urandom_range(1, 30);
			send_message(len, pick_reader(len), $urandom_range(1, 3), 1'b0);
		end else if (r < 92) begin
			send_message(0, $urandom_range(0, 4095), $urandom_range(1, 3), 1'b1);
		end else if (r < 96) begin
			// stray bytes with no first marker
			repeat ($urandom_range(1, 3))
				push_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
					12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
		end else begin
			len = $urandom_range(0, 4095);
			send_message(len, pick_reader(len), 1, 1'b1);
		end
	endtask

	// Wait for every owed status, then let header writes drain
	task automatic settle();
		@(negedge clk);
		msg_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ring_size(input logic [RING_SIZE_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_ring_size(v);
	endtask

	// Directed: field extremes, rejects, wrap, abandoned and short messages
	task automatic run_directed();
		int unsigned cand;
		send_mode = 0;
		sink_mode = 0;
		push_byte(8'h00, 1'b0, 1'b1, 12'd0, 12'd0);          // byte with no message open
		push_byte(8'hFF, 1'b1, 1'b1, 12'd0, 12'hFFF);        // zero length
		push_byte(8'h5A, 1'b1, 1'b1, 12'd1, 12'd0);          // single-item message
		push_byte(8'h00, 1'b1, 1'b0, 12'd2, 12'd0);          // length 2 with two extra bytes
		push_byte(8'hFF, 1'b0, 1'b0, 12'hFFF, 12'hFFF);
		push_byte(8'hAB, 1'b0, 1'b0, 12'd0, 12'd0);
		push_byte(8'hCD, 1'b0, 1'b1, 12'd0, 12'd0);
		send_message(4095, 0, 2, 1'b1);                      // cannot fit anywhere
		cand = sb.next_candidate();
		send_message(10, cand + 8, 1, 1'b1);                 // would overrun the reader
		send_message(5, 0, 2, 1'b0);                         // abandoned
		send_message(3, 0, 3, 1'b1);
		send_message(4000, 0, 2, 1'b1);                      // big and short, fills the ring
		send_message(20, 4095, 2, 1'b1);                     // wraps to 0
		send_message(4000, 4095, 1, 1'b1);
		send_message(100, 50, 1, 1'b1);                      // no room at end, reader too close
	endtask

	// Stimulus
	initial begin
		logic [RING_SIZE_W-1:0] size_plan [N_PHASES];
		logic [RING_SIZE_W-1:0] size_now;
		int unsigned            phase_start;
		size_plan = '{13'd8191, 13'd32, 13'd600, 13'd0, 13'd100, 13'd4096, 13'd1500};
		sb = new();
		items_used    = 0;
		messages_sent = 0;
		send_mode     = 0;
		sink_mode     = 0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		msg_ch.valid          = 1'b0;
		msg_ch.payload_byte   = '0;
		msg_ch.first_byte     = 1'b0;
		msg_ch.last_byte      = 1'b0;
		msg_ch.message_length = '0;
		msg_ch.reader_offset  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		// Random phases, each under its own ring size
		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			size_now = (p == 3) ? 13'($urandom_range(32, 8191)) : size_plan[p];
			write_ring_size(size_now);
			send_mode   = p % 3;
			sink_mode   = (p + 1) % 3;
			phase_start = items_used;
			while (items_used - phase_start < PHASE_ITEMS)
				random_message();
		end

		settle();
		$display("Run covered %0d messages, %0d items used, %0d statuses checked",
			messages_sent, items_used, sb.checked);
		$display("Placed %0d (%0d wrapped), rejected %0d too long, %0d zero length",
			sb.n_written, sb.n_wrapped, sb.n_too_long, sb.n_zero_len);
		if (sb.failures() == 0) begin
			$display("PASS message_ring_writer_unit");
		end else begin
			$display("%0d failures", sb.failures());
			$display("FAIL message_ring_writer_unit");
		end
		$finish;
	end

endmodule
